// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the look-at view matrix block.
// Needs clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LAVM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LAVM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/lavm_pkg.sv =====
// Shared types, widths and helper functions of the look-at view matrix block.
// No dependencies; used by lavm_norm and look_at_view_matrix.
`default_nettype none
package lavm_pkg;

  localparam int COORD_W    = 32;  // input coordinates
  localparam int DIFF_W     = 33;  // eye - target, and sign-extended up
  localparam int AXIS_BITS  = 16;  // fraction bits of a unit axis
  localparam int AXIS_W     = 18;  // signed Q1.16 axis component
  localparam int CROSS_W    = 35;  // cross product of two axes, Q2.32
  localparam int PROD_W     = 36;  // one axis by axis product
  localparam int NORM_W     = 30;  // magnitudes after scaling into [2^29, 2^30)
  localparam int NORM_LO_POS = NORM_W - 1;
  localparam int DOT_PROD_W = AXIS_W + COORD_W;  // axis by eye product
  localparam int DOT_W      = DOT_PROD_W + 2;    // sum of three products

  localparam logic [AXIS_W-1:0] AXIS_ONE = AXIS_W'(1) << AXIS_BITS;

  typedef logic [2:0][AXIS_W-1:0]  vec_axis_t;
  typedef logic [2:0][COORD_W-1:0] vec_coord_t;

  typedef enum logic [1:0] {
    ROW_RIGHT = 2'd0,
    ROW_UP    = 2'd1,
    ROW_FWD   = 2'd2
  } row_t;

  // Status that travels with a normalized vector.
  typedef struct packed {
    logic valid;
    logic nz;     // the input vector was not zero
  } nrm_stat_t;

  // Round a Q2.32 value to Q1.16 half away from zero, clamp to +-1.0.
  function automatic logic [AXIS_W-1:0] round_clamp_axis(input logic [CROSS_W-1:0] c);
    logic [CROSS_W-1:0] mag;
    logic [CROSS_W-1:0] m;
    logic [AXIS_W-1:0]  r;
    mag = c[CROSS_W-1] ? (~c + CROSS_W'(1)) : c;
    m = (mag + (CROSS_W'(1) << (AXIS_BITS - 1))) >> AXIS_BITS;
    if (m > CROSS_W'(AXIS_ONE)) begin
      m = CROSS_W'(AXIS_ONE);
    end
    r = m[AXIS_W-1:0];
    return c[CROSS_W-1] ? (~r + AXIS_W'(1)) : r;
  endfunction

  // Negate a dot product rounded from Q.32 to Q.16, saturated to 32 bits.
  function automatic logic [COORD_W-1:0] neg_round_sat(input logic [DOT_W-1:0] s);
    logic [DOT_W-1:0]   mag;
    logic [DOT_W-1:0]   m;
    logic [COORD_W-1:0] t;
    mag = s[DOT_W-1] ? (~s + DOT_W'(1)) : s;
    m = (mag + (DOT_W'(1) << (AXIS_BITS - 1))) >> AXIS_BITS;
    if (s[DOT_W-1]) begin
      if (m > DOT_W'({1'b0, {(COORD_W-1){1'b1}}})) begin
        t = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        t = m[COORD_W-1:0];
      end
    end else begin
      if (m > (DOT_W'(1) << (COORD_W - 1))) begin
        t = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        t = ~m[COORD_W-1:0] + COORD_W'(1);
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lavm_norm.sv =====
// Pipelined vector normalizer: scale, sum of squares, bit-per-stage square root
// and bit-per-stage division for three lanes. Depends on lavm_pkg.
`default_nettype none
module lavm_norm #(
  parameter int IN_W   = lavm_pkg::CROSS_W,
  parameter int SIDE_W = lavm_pkg::COORD_W
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2:0][IN_W-1:0]                in_vec,
  input  logic [SIDE_W-1:0]                   in_side,
  output lavm_pkg::nrm_stat_t                 out_stat,
  output lavm_pkg::vec_axis_t                 out_axis,
  output logic [SIDE_W-1:0]                   out_side
);
  import lavm_pkg::*;

  localparam int PW         = $clog2(IN_W);
  localparam int SQ_W       = 2 * NORM_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int RV_W       = SUM_W + 1;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int LEN_W      = ROOT_STEPS;
  localparam int QUO_W      = AXIS_BITS + 1;
  localparam int REM_W      = NORM_W + AXIS_BITS + 1;

  typedef struct packed {
    logic                   valid;
    logic [SIDE_W-1:0]      side;
    logic [2:0]             neg;
    logic [2:0][IN_W-1:0]   mag;
    logic [IN_W-1:0]        mx;
  } s1_t;

  typedef struct packed {
    logic                   valid;
    logic [SIDE_W-1:0]      side;
    logic [2:0]             neg;
    logic [2:0][IN_W-1:0]   mag;
    logic                   nz;
    logic [PW-1:0]          pos;
  } s2_t;

  typedef struct packed {
    logic                   valid;
    logic [SIDE_W-1:0]      side;
    logic [2:0]             neg;
    logic                   nz;
    logic [2:0][NORM_W-1:0] m;
    logic [2:0][SQ_W-1:0]   sq;
  } s3_t;

  typedef struct packed {
    logic                   valid;
    logic [SIDE_W-1:0]      side;
    logic [2:0]             neg;
    logic                   nz;
    logic [2:0][NORM_W-1:0] m;
    logic [RV_W-1:0]        v;
    logic [RV_W-1:0]        r;
  } rt_t;

  typedef struct packed {
    logic                   valid;
    logic [SIDE_W-1:0]      side;
    logic [2:0]             neg;
    logic                   nz;
    logic [LEN_W-1:0]       len;
    logic [2:0][REM_W-1:0]  rem;
    logic [2:0][QUO_W-1:0]  q;
  } dv_t;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s3_t s4, s4_next;
  rt_t rt [ROOT_STEPS+1];
  rt_t rt0_next;
  dv_t dv [QUO_W+1];
  dv_t dv0_next;

  // Magnitudes and their maximum.
  always_comb begin
    s1_next.valid = in_valid;
    s1_next.side  = in_side;
    s1_next.mx    = '0;
    for (int i = 0; i < 3; i++) begin
      s1_next.neg[i] = in_vec[i][IN_W-1];
      s1_next.mag[i] = in_vec[i][IN_W-1] ? (~in_vec[i] + IN_W'(1)) : in_vec[i];
    end
    for (int i = 0; i < 3; i++) begin
      if (s1_next.mag[i] > s1_next.mx) begin
        s1_next.mx = s1_next.mag[i];
      end
    end
  end

  // Position of the leading one of the maximum.
  always_comb begin
    s2_next.valid = s1.valid;
    s2_next.side  = s1.side;
    s2_next.neg   = s1.neg;
    s2_next.mag   = s1.mag;
    s2_next.nz    = |s1.mx;
    s2_next.pos   = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (s1.mx[b]) begin
        s2_next.pos = PW'(b);
      end
    end
  end

  // Common shift that brings the maximum into [2^29, 2^30).
  always_comb begin
    logic [IN_W+NORM_W-1:0] wide;
    logic [IN_W-1:0]        nar;
    s3_next.valid = s2.valid;
    s3_next.side  = s2.side;
    s3_next.neg   = s2.neg;
    s3_next.nz    = s2.nz;
    s3_next.sq    = '0;
    wide = '0;
    nar  = '0;
    for (int i = 0; i < 3; i++) begin
      if (s2.pos > PW'(NORM_LO_POS)) begin
        nar = s2.mag[i] >> (s2.pos - PW'(NORM_LO_POS));
        s3_next.m[i] = nar[NORM_W-1:0];
      end else begin
        wide = {{NORM_W{1'b0}}, s2.mag[i]} << (PW'(NORM_LO_POS) - s2.pos);
        s3_next.m[i] = wide[NORM_W-1:0];
      end
    end
  end

  // Squares of the scaled magnitudes.
  always_comb begin
    s4_next = s3;
    for (int i = 0; i < 3; i++) begin
      s4_next.sq[i] = s3.m[i] * s3.m[i];
    end
  end

  // Sum of squares seeds the root.
  always_comb begin
    rt0_next.valid = s4.valid;
    rt0_next.side  = s4.side;
    rt0_next.neg   = s4.neg;
    rt0_next.nz    = s4.nz;
    rt0_next.m     = s4.m;
    rt0_next.v     = RV_W'(s4.sq[0]) + RV_W'(s4.sq[1]) + RV_W'(s4.sq[2]);
    rt0_next.r     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid    <= 1'b0;
      s2.valid    <= 1'b0;
      s3.valid    <= 1'b0;
      s4.valid    <= 1'b0;
      rt[0].valid <= 1'b0;
    end else if (en) begin
      s1    <= s1_next;
      s2    <= s2_next;
      s3    <= s3_next;
      s4    <= s4_next;
      rt[0] <= rt0_next;
    end
  end

  // One result bit of the integer square root per stage.
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam int BPOS = SUM_W - 2 - 2 * k;
    rt_t nxt;
    always_comb begin
      logic [RV_W-1:0] t;
      nxt = rt[k];
      t = rt[k].r + (RV_W'(1) << BPOS);
      if (rt[k].v >= t) begin
        nxt.v = rt[k].v - t;
        nxt.r = (rt[k].r >> 1) + (RV_W'(1) << BPOS);
      end else begin
        nxt.r = rt[k].r >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        rt[k+1].valid <= 1'b0;
      end else if (en) begin
        rt[k+1] <= nxt;
      end
    end
  end

  // Dividend m * 2^16 + len / 2 for each lane.
  always_comb begin
    logic [LEN_W-1:0] len;
    len = rt[ROOT_STEPS].r[LEN_W-1:0];
    dv0_next.valid = rt[ROOT_STEPS].valid;
    dv0_next.side  = rt[ROOT_STEPS].side;
    dv0_next.neg   = rt[ROOT_STEPS].neg;
    dv0_next.nz    = rt[ROOT_STEPS].nz;
    dv0_next.len   = len;
    dv0_next.q     = '0;
    for (int i = 0; i < 3; i++) begin
      dv0_next.rem[i] = (REM_W'(rt[ROOT_STEPS].m[i]) << AXIS_BITS) + REM_W'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (en) begin
      dv[0] <= dv0_next;
    end
  end

  // One quotient bit per stage, most significant first, three lanes.
  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    localparam int QB = QUO_W - 1 - s;
    dv_t nxt;
    always_comb begin
      logic [REM_W-1:0] dsr;
      nxt = dv[s];
      dsr = REM_W'(dv[s].len) << QB;
      for (int i = 0; i < 3; i++) begin
        if (dv[s].rem[i] >= dsr) begin
          nxt.rem[i]  = dv[s].rem[i] - dsr;
          nxt.q[i][QB] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1].valid <= 1'b0;
      end else if (en) begin
        dv[s+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stat.valid <= 1'b0;
    end else if (en) begin
      out_stat.valid <= dv[QUO_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stat.nz <= dv[QUO_W].nz;
      out_side    <= dv[QUO_W].side;
      for (int i = 0; i < 3; i++) begin
        out_axis[i] <= dv[QUO_W].neg[i] ? (~{1'b0, dv[QUO_W].q[i]} + AXIS_W'(1))
                                         : {1'b0, dv[QUO_W].q[i]};
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/look_at_view_matrix.sv =====
// Top level of the fixed-point look-at view matrix block.
// Depends on lavm_pkg, lavm_norm and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Each input transaction carries an eye point, a target point and an up hint, all
// signed Q16.16. The block forms forward = normalize(eye - target), right =
// normalize(cross(normalize(up), forward)) and up' = cross(forward, right), and
// returns three output transactions in the order right, up', forward. Each row holds
// the unit axis in Q1.16 and the translation -dot(axis, eye), rounded half away
// from zero and saturated to 32 bits; last_row marks the forward row. When eye
// equals target, up is zero, or up is parallel to forward, all three rows come out
// with degenerate set and zero axis and translation. The datapath is one pipeline
// of about 119 register stages: two normalizers run side by side on eye - target
// and up, then the cross product, a third normalizer, the second cross product and
// the dot products follow. Each normalizer spends 31 stages on the square root and
// 17 on the divisions, one result bit per stage. An item finishing the pipeline
// lands in a three-row output buffer; the whole pipeline advances whenever that
// buffer is empty or is handing out its last row. Throughput is therefore set by
// the output channel: a new input transaction is taken only while the buffer is
// empty or as the last row of the previous matrix is handed out.
module look_at_view_matrix (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  eye_x,
  input  logic signed [31:0]  eye_y,
  input  logic signed [31:0]  eye_z,
  input  logic signed [31:0]  target_x,
  input  logic signed [31:0]  target_y,
  input  logic signed [31:0]  target_z,
  input  logic signed [31:0]  up_x,
  input  logic signed [31:0]  up_y,
  input  logic signed [31:0]  up_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          row_index,
  output logic signed [17:0]  axis_x,
  output logic signed [17:0]  axis_y,
  output logic signed [17:0]  axis_z,
  output logic signed [31:0]  translation,
  output logic                degenerate,
  output logic                last_row
);
  import lavm_pkg::*;

  localparam int SIDE3_W = 1 + 3 * AXIS_W + 3 * COORD_W;

  // The whole pipeline moves together when the output buffer can take an item.
  logic advance;

  // Input register: eye, eye - target and the sign-extended up hint.
  logic                     t0_valid;
  vec_coord_t               t0_eye;
  logic [2:0][DIFF_W-1:0]   t0_d;
  logic [2:0][DIFF_W-1:0]   t0_up;

  // First pair of normalizers.
  nrm_stat_t                st1, st2;
  vec_axis_t                f_ax, nu_ax;
  logic [2*COORD_W-1:0]     side1;
  logic [COORD_W-1:0]       side2;

  // Cross product of normalized up and forward.
  logic                     c1_valid, c1_ok;
  vec_axis_t                c1_f;
  vec_coord_t               c1_eye;
  logic signed [PROD_W-1:0] c1_p [6];
  logic                     c2_valid;
  logic [2:0][CROSS_W-1:0]  c2_cr;
  logic [SIDE3_W-1:0]       c2_side;

  // Third normalizer gives the right axis.
  nrm_stat_t                st3;
  vec_axis_t                r_ax;
  logic [SIDE3_W-1:0]       side3;
  logic                     n3_ok;
  vec_axis_t                n3_f;
  vec_coord_t               n3_eye;

  // Cross product of forward and right gives up'.
  logic                     d1_valid, d1_ok;
  vec_axis_t                d1_r, d1_f;
  vec_coord_t               d1_eye;
  logic signed [PROD_W-1:0] d1_p [6];
  logic                     d2_valid, d2_ok;
  vec_axis_t                d2_r, d2_f;
  vec_coord_t               d2_eye;
  logic [2:0][CROSS_W-1:0]  d2_c;
  logic                     d3_valid, d3_ok;
  vec_axis_t                d3_r, d3_u, d3_f;
  vec_coord_t               d3_eye;

  // Dot products with the eye, one row per axis.
  logic                          p_valid, p_ok;
  vec_axis_t                     p_ax [3];
  logic signed [DOT_PROD_W-1:0]  p_prod [3][3];
  logic                          s_valid, s_ok;
  vec_axis_t                     s_ax [3];
  logic [DOT_W-1:0]              s_sum [3];

  // Three-row output buffer.
  logic                     ser_valid;
  row_t                     ser_row;
  logic                     ser_deg;
  vec_axis_t                ser_ax [3];
  logic [COORD_W-1:0]       ser_tr [3];

  assign advance  = !ser_valid || ((ser_row == ROW_FWD) && out_ready);
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_valid <= 1'b0;
    end else if (advance) begin
      t0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t0_eye   <= {eye_z, eye_y, eye_x};
      t0_d[0]  <= {eye_x[31], eye_x} - {target_x[31], target_x};
      t0_d[1]  <= {eye_y[31], eye_y} - {target_y[31], target_y};
      t0_d[2]  <= {eye_z[31], eye_z} - {target_z[31], target_z};
      t0_up    <= {{up_z[31], up_z}, {up_y[31], up_y}, {up_x[31], up_x}};
    end
  end

  // Forward axis; this lane carries the x and y of the eye.
  lavm_norm #(
    .IN_W   (DIFF_W),
    .SIDE_W (2 * COORD_W)
  ) u_norm_fwd (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_valid (t0_valid),
    .in_vec   (t0_d),
    .in_side  ({t0_eye[1], t0_eye[0]}),
    .out_stat (st1),
    .out_axis (f_ax),
    .out_side (side1)
  );

  // Normalized up hint; this lane carries the z of the eye.
  lavm_norm #(
    .IN_W   (DIFF_W),
    .SIDE_W (COORD_W)
  ) u_norm_up (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_valid (t0_valid),
    .in_vec   (t0_up),
    .in_side  (t0_eye[2]),
    .out_stat (st2),
    .out_axis (nu_ax),
    .out_side (side2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
      c2_valid <= 1'b0;
    end else if (advance) begin
      c1_valid <= st1.valid;
      c2_valid <= c1_valid;
    end
  end

  // cross(nu, f): products in one stage, differences in the next.
  always_ff @(posedge clk) begin
    if (advance) begin
      c1_ok   <= st1.nz && st2.nz;
      c1_f    <= f_ax;
      c1_eye  <= {side2, side1};
      c1_p[0] <= $signed(nu_ax[1]) * $signed(f_ax[2]);
      c1_p[1] <= $signed(nu_ax[2]) * $signed(f_ax[1]);
      c1_p[2] <= $signed(nu_ax[2]) * $signed(f_ax[0]);
      c1_p[3] <= $signed(nu_ax[0]) * $signed(f_ax[2]);
      c1_p[4] <= $signed(nu_ax[0]) * $signed(f_ax[1]);
      c1_p[5] <= $signed(nu_ax[1]) * $signed(f_ax[0]);
      c2_cr[0] <= CROSS_W'(c1_p[0] - c1_p[1]);
      c2_cr[1] <= CROSS_W'(c1_p[2] - c1_p[3]);
      c2_cr[2] <= CROSS_W'(c1_p[4] - c1_p[5]);
      c2_side  <= {c1_ok, c1_f, c1_eye};
    end
  end

  lavm_norm #(
    .IN_W   (CROSS_W),
    .SIDE_W (SIDE3_W)
  ) u_norm_right (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_valid (c2_valid),
    .in_vec   (c2_cr),
    .in_side  (c2_side),
    .out_stat (st3),
    .out_axis (r_ax),
    .out_side (side3)
  );

  assign {n3_ok, n3_f, n3_eye} = side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
      d2_valid <= 1'b0;
      d3_valid <= 1'b0;
      p_valid  <= 1'b0;
      s_valid  <= 1'b0;
    end else if (advance) begin
      d1_valid <= st3.valid;
      d2_valid <= d1_valid;
      d3_valid <= d2_valid;
      p_valid  <= d3_valid;
      s_valid  <= p_valid;
    end
  end

  // cross(f, r), then round to Q1.16 and clamp; up' is not renormalized.
  always_ff @(posedge clk) begin
    if (advance) begin
      d1_ok   <= n3_ok && st3.nz;
      d1_r    <= r_ax;
      d1_f    <= n3_f;
      d1_eye  <= n3_eye;
      d1_p[0] <= $signed(n3_f[1]) * $signed(r_ax[2]);
      d1_p[1] <= $signed(n3_f[2]) * $signed(r_ax[1]);
      d1_p[2] <= $signed(n3_f[2]) * $signed(r_ax[0]);
      d1_p[3] <= $signed(n3_f[0]) * $signed(r_ax[2]);
      d1_p[4] <= $signed(n3_f[0]) * $signed(r_ax[1]);
      d1_p[5] <= $signed(n3_f[1]) * $signed(r_ax[0]);

      d2_ok   <= d1_ok;
      d2_r    <= d1_r;
      d2_f    <= d1_f;
      d2_eye  <= d1_eye;
      d2_c[0] <= CROSS_W'(d1_p[0] - d1_p[1]);
      d2_c[1] <= CROSS_W'(d1_p[2] - d1_p[3]);
      d2_c[2] <= CROSS_W'(d1_p[4] - d1_p[5]);

      d3_ok   <= d2_ok;
      d3_r    <= d2_r;
      d3_f    <= d2_f;
      d3_eye  <= d2_eye;
      for (int i = 0; i < 3; i++) begin
        d3_u[i] <= round_clamp_axis(d2_c[i]);
      end
    end
  end

  // Nine axis-by-eye products, then one sum per row.
  always_ff @(posedge clk) begin
    if (advance) begin
      p_ok     <= d3_ok;
      p_ax[0]  <= d3_r;
      p_ax[1]  <= d3_u;
      p_ax[2]  <= d3_f;
      for (int i = 0; i < 3; i++) begin
        p_prod[0][i] <= $signed(d3_r[i]) * $signed(d3_eye[i]);
        p_prod[1][i] <= $signed(d3_u[i]) * $signed(d3_eye[i]);
        p_prod[2][i] <= $signed(d3_f[i]) * $signed(d3_eye[i]);
      end

      s_ok <= p_ok;
      s_ax <= p_ax;
      for (int k = 0; k < 3; k++) begin
        s_sum[k] <= DOT_W'(p_prod[k][0]) + DOT_W'(p_prod[k][1]) + DOT_W'(p_prod[k][2]);
      end
    end
  end

  // Output buffer: loads a whole matrix, then hands out one row per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_row   <= ROW_RIGHT;
    end else if (advance) begin
      ser_valid <= s_valid;
      ser_row   <= ROW_RIGHT;
    end else if (out_ready) begin
      unique case (ser_row)
        ROW_RIGHT: ser_row <= ROW_UP;
        ROW_UP:    ser_row <= ROW_FWD;
        default:   ser_row <= ROW_FWD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ser_deg <= !s_ok;
      for (int k = 0; k < 3; k++) begin
        ser_ax[k] <= s_ok ? s_ax[k] : '0;
        ser_tr[k] <= s_ok ? neg_round_sat(s_sum[k]) : '0;
      end
    end
  end

  assign out_valid   = ser_valid;
  assign row_index   = ser_row;
  assign axis_x      = ser_ax[ser_row][0];
  assign axis_y      = ser_ax[ser_row][1];
  assign axis_z      = ser_ax[ser_row][2];
  assign translation = ser_tr[ser_row];
  assign degenerate  = ser_deg;
  assign last_row    = (ser_row == ROW_FWD);

  // The two front normalizers must stay in lockstep.
  `LAVM_ASSERT_NOW(a_norm_lockstep, st1.valid || st2.valid, st1.valid && st2.valid)
  // No new transaction enters while rows of the current matrix are still pending.
  `LAVM_ASSERT_NOW(a_hold_input, out_valid && (row_index != ROW_FWD), !in_ready)
  // The right row is always followed by the up row of the same matrix.
  `LAVM_ASSERT_NEXT(a_row_step, out_valid && out_ready && (row_index == ROW_RIGHT), out_valid && (row_index == ROW_UP))
  // A degenerate basis gives all-zero rows.
  `LAVM_ASSERT_NOW(a_degen_zero, out_valid && degenerate, (translation == '0) && (axis_x == '0) && (axis_y == '0) && (axis_z == '0))

endmodule
`default_nettype wire

// ===== bench/look_at_checker.sv =====
// Checker for the look-at view matrix block: predicts the three rows of every
// accepted input transaction and compares each output transaction. Needs lavm_pkg.
`timescale 1ns / 100ps
module look_at_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] up_x,
  input  logic signed [31:0] up_y,
  input  logic signed [31:0] up_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         row_index,
  input  logic signed [17:0] axis_x,
  input  logic signed [17:0] axis_y,
  input  logic signed [17:0] axis_z,
  input  logic signed [31:0] translation,
  input  logic               degenerate,
  input  logic               last_row,
  output int                 fail_count,
  output int                 rows_pending
);
  import lavm_pkg::*;

  typedef struct packed {
    logic [1:0]         idx;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic signed [17:0] az;
    logic signed [31:0] tr;
    logic               degen;
    logic               last;
  } view_row_t;

  typedef longint signed vec3_t [3];

  view_row_t expected_rows[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Shift right with rounding half away from zero.
  function automatic longint signed shift_round(longint signed v, int s);
    longint unsigned m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  // Scales the magnitudes into [2^29, 2^30) and divides by the length.
  function automatic bit unit_vector(input vec3_t c, output vec3_t u);
    longint unsigned m[3], mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << AXIS_BITS) + (len >> 1)) / len;
      u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic void cross_product(input vec3_t a, input vec3_t b, output vec3_t o);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  task automatic predict_view_rows();
    vec3_t eye, dir, hint, nhint, fwd, side, rgt, cup, upv, ax;
    bit ok;
    longint signed s, t;
    view_row_t row;
    eye = '{eye_x, eye_y, eye_z};
    dir = '{longint'(eye_x) - target_x, longint'(eye_y) - target_y,
            longint'(eye_z) - target_z};
    hint = '{up_x, up_y, up_z};
    ok = unit_vector(dir, fwd);
    if (ok) ok = unit_vector(hint, nhint);
    if (ok) begin
      cross_product(nhint, fwd, side);
      ok = unit_vector(side, rgt);
    end
    if (ok) begin
      cross_product(fwd, rgt, cup);
      for (int i = 0; i < 3; i++) begin
        upv[i] = shift_round(cup[i], AXIS_BITS);
        if (upv[i] > 65536) upv[i] = 65536;
        if (upv[i] < -65536) upv[i] = -65536;
      end
    end
    for (int k = 0; k < 3; k++) begin
      row = '0;
      row.idx = (k == 0) ? ROW_RIGHT : (k == 1) ? ROW_UP : ROW_FWD;
      row.last = (k == 2);
      if (ok) begin
        ax = (k == 0) ? rgt : (k == 1) ? upv : fwd;
        s = ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2];
        t = -shift_round(s, AXIS_BITS);
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        row.ax = ax[0][17:0];
        row.ay = ax[1][17:0];
        row.az = ax[2][17:0];
        row.tr = t[31:0];
      end else begin
        row.degen = 1'b1;
      end
      expected_rows.insert(expected_rows.size(), row);
    end
  endtask

  always @(posedge clk) begin
    view_row_t got, want;
    if (rst) begin
      fail_count   <= 0;
      rows_pending <= 0;
    end else begin
      if (in_valid && in_ready) predict_view_rows();
      if (out_valid && out_ready) begin
        got = '{row_index, axis_x, axis_y, axis_z, translation, degenerate, last_row};
        if (expected_rows.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("Unexpected row: %p", got);
        end else begin
          want = expected_rows.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("Row mismatch: expected %p, got %p", want, got);
          end
        end
      end
      rows_pending <= expected_rows.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the look-at view matrix bench: drives input transactions, stalls the
// output side and gives the verdict. Needs lavm_pkg, look_at_checker and the RTL.
`timescale 1ns / 100ps
module testbench;
  import lavm_pkg::*;

  // The pipeline is about 119 stages deep; we allow well beyond that at the end.
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic signed [31:0] up_x = '0, up_y = '0, up_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] row_index;
  logic signed [17:0] axis_x, axis_y, axis_z;
  logic signed [31:0] translation;
  logic degenerate, last_row;
  int fail_count, rows_pending;
  int cycle_count = 0;
  bit stall_free = 1'b0;

  always #10 clk = ~clk;

  look_at_view_matrix dut (.*);
  look_at_checker checker_inst (.*);

  // The run is stopped outright if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: random stalls, with stretches where ready simply stays high.
  initial begin
    int wait_cycles;
    @(posedge clk iff !rst);
    forever begin
      wait_cycles = stall_free ? 0 : $urandom_range(0, 8);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  // Offers one input transaction, after a random gap unless stall_free is set, and waits for acceptance.
  task automatic send_camera(input logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
    int gap;
    gap = stall_free ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {eye_x, eye_y, eye_z} <= {ex, ey, ez};
    {target_x, target_y, target_z} <= {tx, ty, tz};
    {up_x, up_y, up_z} <= {ux, uy, uz};
    @(posedge clk iff in_ready);
  endtask

  // Mostly small and moderate coordinates, sometimes any 32-bit pattern.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      2: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
      default: return $urandom_range(0, 64) - 32;
    endcase
  endfunction

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;

  initial begin
    logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: ordinary cameras, degenerate cases and the extremes of the fields.
    send_camera(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
    send_camera(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0);  // eye equals target
    send_camera(0, 0, ONE, 0, 0, 0, 0, 0, 0);                              // up is zero
    send_camera(0, 0, ONE, 0, 0, 0, 0, 0, 7 * ONE);                        // up along forward
    send_camera(0, 0, ONE, 0, 0, 0, 0, 0, -ONE);                           // up opposite forward
    send_camera(MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, ONE, 0);
    send_camera(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV, 1);
    send_camera(MAXV, MINV, MAXV, 0, 0, 0, MAXV, MAXV, MINV);               // translation saturates
    send_camera(MINV, MAXV, MINV, 0, 0, 1, 1, 0, 0);
    send_camera(1, 0, 0, 0, 0, 0, 0, 1, 0);                                 // tiny vectors
    send_camera(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1, 0, 0);
    send_camera(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                32'h5555_5555, 32'hAAAA_AAAA);
    send_camera(0, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE);                     // up opposite forward
    send_camera(3 * ONE, ONE, -4 * ONE, 0, 0, 0, ONE, 0, ONE);

    // Random: mostly well-formed cameras, with some parallel and zero cases.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      stall_free = (n % 60) >= 45;
      ex = pick_coord(); ey = pick_coord(); ez = pick_coord();
      tx = pick_coord(); ty = pick_coord(); tz = pick_coord();
      ux = pick_coord(); uy = pick_coord(); uz = pick_coord();
      case ($urandom_range(0, 19))
        0: {tx, ty, tz} = {ex, ey, ez};
        1: {ux, uy, uz} = '0;
        2: {ux, uy, uz} = {ex - tx, ey - ty, ez - tz};
        default: ;
      endcase
      send_camera(ex, ey, ez, tx, ty, tz, ux, uy, uz);
    end
    in_valid <= 1'b0;
    stall_free = 1'b0;

    // Let every expected row come out, then watch for stray rows.
    @(posedge clk iff rows_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lavm_pkg.sv
rtl/core/lavm_norm.sv
rtl/core/look_at_view_matrix.sv
bench/look_at_checker.sv
bench/testbench.sv
